// ----- rtl/brat_pkg.sv -----
// ----------------------------------------------------------------------------
// brat_pkg
// shared constants for the best rational approximation block
// ----------------------------------------------------------------------------
package brat_pkg;

    localparam int FRACTION_WIDTH_DEF = 64;
    localparam int LIMIT_WIDTH_DEF    = 32;

    localparam int FIELD_W  = 64;
    localparam int RESULT_W = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [31:0] LIMIT_RESET = 32'd1048575;

    localparam logic REG_NUM_LIMIT = 1'b0;
    localparam logic REG_DEN_LIMIT = 1'b1;

endpackage

// ----- rtl/best_rational_approximation.sv -----
// ----------------------------------------------------------------------------
// best_rational_approximation
// continued-fraction expansion of a fraction, returning the best convergent
// that stays within a numerator limit and a denominator limit
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  in        input      in_valid, in_ready, fraction_top, fraction_bottom
//  out       output     out_valid, out_ready, approx_top, approx_bottom
//  apb       config     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  each expansion step is one check state, one restoring division of
//  FRACTION_WIDTH quotient bits and the multiply, add and update states
//  S_MULP, S_ADDP, S_MULQ, S_ADDQ and S_UPD on one shared multiplier and
//  adder; out_valid rises from S_DONE, and the block returns to idle before
//  the next word can be taken
//  in_ready is high only while idle; one finished word may wait at the output
//  while the next word is taken in
//  rst_n clears control state and sets both limits to 1048575
// ----------------------------------------------------------------------------
module best_rational_approximation #(
    parameter int FRACTION_WIDTH = brat_pkg::FRACTION_WIDTH_DEF,
    parameter int LIMIT_WIDTH    = brat_pkg::LIMIT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [brat_pkg::FIELD_W-1:0]  fraction_top,
    input  logic [brat_pkg::FIELD_W-1:0]  fraction_bottom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [brat_pkg::RESULT_W-1:0] approx_top,
    output logic [brat_pkg::RESULT_W-1:0] approx_bottom,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brat_pkg::ADDR_W-1:0]   paddr,
    input  logic [brat_pkg::DATA_W-1:0]   pwdata,
    output logic [brat_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import brat_pkg::*;

    localparam int FW    = FRACTION_WIDTH;
    localparam int LW    = LIMIT_WIDTH;
    localparam int WW    = (FW > LW) ? FW : LW;
    localparam int PW    = 2 * LW;
    localparam int CNT_W = $clog2(FW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MULP,
        S_ADDP,
        S_MULQ,
        S_ADDQ,
        S_UPD,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     nlim_reg;
    logic [LW-1:0]     dlim_reg;
    logic [FW-1:0]     num_reg;
    logic [FW-1:0]     den_reg;
    logic [FW-1:0]     rem_reg;
    logic [FW-1:0]     quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LW-1:0]     p_prev_reg;
    logic [LW-1:0]     q_prev_reg;
    logic [LW-1:0]     p_cur_reg;
    logic [LW-1:0]     q_cur_reg;
    logic [LW-1:0]     p_next_reg;
    logic [LW-1:0]     q_next_reg;
    logic [PW-1:0]     prod_reg;
    logic              big_reg;
    logic              p_over_reg;
    logic              q_over_reg;
    logic [LW-1:0]     res_top_reg;
    logic [LW-1:0]     res_bot_reg;
    logic              out_valid_reg;
    logic [RESULT_W-1:0] approx_top_reg;
    logic [RESULT_W-1:0] approx_bot_reg;

    // divider step
    logic [FW:0]   rem_sh;
    logic [FW:0]   rem_diff;
    logic          rem_ge;
    logic [FW-1:0] rem_next;
    logic [FW-1:0] quo_next;

    // shared multiplier and adder
    logic [WW-1:0] quo_ext;
    logic          quo_big;
    logic [LW-1:0] mul_b;
    logic [PW-1:0] mul_prod;
    logic [LW-1:0] add_base;
    logic [LW-1:0] add_lim;
    logic [PW:0]   add_sum;
    logic          add_over;

    logic          wr_en;
    logic          out_free;

    assign rem_sh   = {rem_reg, quo_reg[FW-1]};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign rem_next = rem_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
    assign quo_next = {quo_reg[FW-2:0], rem_ge};

    assign quo_ext  = WW'(quo_reg);
    assign quo_big  = (quo_ext >> LW) != '0;
    assign mul_b    = (state_reg == S_MULP) ? p_cur_reg : q_cur_reg;
    assign mul_prod = {{LW{1'b0}}, quo_ext[LW-1:0]} * {{LW{1'b0}}, mul_b};
    assign add_base = (state_reg == S_ADDP) ? p_prev_reg : q_prev_reg;
    assign add_lim  = (state_reg == S_ADDP) ? nlim_reg : dlim_reg;
    assign add_sum  = {1'b0, prod_reg} + (PW+1)'(add_base);
    assign add_over = big_reg || (add_sum > (PW+1)'(add_lim));

    assign out_free = !out_valid_reg || out_ready;

    // configuration registers
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nlim_reg <= LW'(LIMIT_RESET);
            dlim_reg <= LW'(LIMIT_RESET);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_NUM_LIMIT: nlim_reg <= pwdata[LW-1:0];
                REG_DEN_LIMIT: dlim_reg <= pwdata[LW-1:0];
                default:       nlim_reg <= nlim_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_LIMIT: prdata = DATA_W'(nlim_reg);
            REG_DEN_LIMIT: prdata = DATA_W'(dlim_reg);
            default:       prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        num_reg    <= fraction_top[FW-1:0];
                        den_reg    <= fraction_bottom[FW-1:0];
                        p_prev_reg <= '0;
                        q_prev_reg <= LW'(1);
                        p_cur_reg  <= LW'(1);
                        q_cur_reg  <= '0;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (p_cur_reg > nlim_reg || q_cur_reg > dlim_reg)
                    begin
                        res_top_reg <= p_prev_reg;
                        res_bot_reg <= q_prev_reg;
                        state_reg   <= S_DONE;
                    end
                    else if (den_reg == '0)
                    begin
                        res_top_reg <= p_cur_reg;
                        res_bot_reg <= q_cur_reg;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= num_reg;
                        cnt_reg   <= CNT_W'(FW - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        num_reg   <= den_reg;
                        den_reg   <= rem_next;
                        state_reg <= S_MULP;
                    end
                end
                S_MULP:
                begin
                    prod_reg  <= mul_prod;
                    big_reg   <= quo_big && (p_cur_reg != '0);
                    state_reg <= S_ADDP;
                end
                S_ADDP:
                begin
                    p_next_reg <= add_sum[LW-1:0];
                    p_over_reg <= add_over;
                    state_reg  <= S_MULQ;
                end
                S_MULQ:
                begin
                    prod_reg  <= mul_prod;
                    big_reg   <= quo_big && (q_cur_reg != '0);
                    state_reg <= S_ADDQ;
                end
                S_ADDQ:
                begin
                    q_next_reg <= add_sum[LW-1:0];
                    q_over_reg <= add_over;
                    state_reg  <= S_UPD;
                end
                S_UPD:
                begin
                    if (p_over_reg || q_over_reg)
                    begin
                        res_top_reg <= p_cur_reg;
                        res_bot_reg <= q_cur_reg;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        p_prev_reg <= p_cur_reg;
                        q_prev_reg <= q_cur_reg;
                        p_cur_reg  <= p_next_reg;
                        q_cur_reg  <= q_next_reg;
                        state_reg  <= S_CHECK;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        approx_top_reg <= RESULT_W'(res_top_reg);
                        approx_bot_reg <= RESULT_W'(res_bot_reg);
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign approx_top    = approx_top_reg;
    assign approx_bottom = approx_bot_reg;

    // checks
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("division started with zero divisor");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == '0 |=> state_reg == S_MULP)
        else $error("division did not hand over to multiply");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word raised outside done state");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the best rational approximation block: fraction words without a
// known result are expanded as continued fractions by a local predictor,
// which walks the convergents with saturating products. Expected numerator
// and denominator are compared with every result word in order. A directed
// table covers zero fractions, zero limits, all-ones fields and long
// expansions. Random phases follow, each with new limits written over the
// register port. Both handshakes idle at random IDLE_PCT percent of the time,
// with one long output hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module tb_top;

    import brat_pkg::*;

    localparam int          PHASES          = 10;
    localparam int          WORDS_PER_PHASE = 68;
    localparam int          IDLE_PCT        = 21;
    localparam int          HOLD_AT         = 120;
    localparam int          HOLD_CYCLES     = 10000;
    localparam int          END_IDLE        = 200;
    localparam int unsigned CYCLE_LIMIT     = 12000000;

    localparam logic [ADDR_W-1:0]   NUM_LIMIT_ADDR = ADDR_W'(REG_NUM_LIMIT) << 2;
    localparam logic [ADDR_W-1:0]   DEN_LIMIT_ADDR = ADDR_W'(REG_DEN_LIMIT) << 2;
    localparam logic [RESULT_W-1:0] LIM_ONES       = '1;
    localparam logic [FIELD_W-1:0]  FRAC_ONES      = '1;
    localparam logic [FIELD_W-1:0]  FIB_93         = 64'd12200160415121876738;
    localparam logic [FIELD_W-1:0]  FIB_92         = 64'd7540113804746346429;

    typedef struct packed {
        logic [RESULT_W-1:0] top;
        logic [RESULT_W-1:0] bottom;
    } approx_t;

    typedef struct packed {
        logic [RESULT_W-1:0] num_lim;
        logic [RESULT_W-1:0] den_lim;
        logic [FIELD_W-1:0]  top;
        logic [FIELD_W-1:0]  bottom;
        logic                typed;
        approx_t             known;
    } stim_row_t;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                in_valid        = 1'b0;
    logic                in_ready;
    logic [FIELD_W-1:0]  fraction_top    = '0;
    logic [FIELD_W-1:0]  fraction_bottom = '0;
    logic                out_valid;
    logic                out_ready       = 1'b0;
    logic [RESULT_W-1:0] approx_top;
    logic [RESULT_W-1:0] approx_bottom;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [ADDR_W-1:0]   paddr           = '0;
    logic [DATA_W-1:0]   pwdata          = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    approx_t             pending_approx[$];
    logic [RESULT_W-1:0] num_limit = LIMIT_RESET;
    logic [RESULT_W-1:0] den_limit = LIMIT_RESET;
    int                  mismatch_count = 0;
    int                  approx_seen    = 0;
    int unsigned         cycle_count    = 0;
    bit                  sender_calm    = 1'b0;
    bit                  hold_done      = 1'b0;

    best_rational_approximation dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fraction_top    (fraction_top),
        .fraction_bottom (fraction_bottom),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .approx_top      (approx_top),
        .approx_bottom   (approx_bottom),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // base + mul * x, saturating at all ones
    function automatic logic [FIELD_W-1:0] sat_mac(input logic [FIELD_W-1:0] base,
                                                   input logic [FIELD_W-1:0] mul,
                                                   input logic [FIELD_W-1:0] x);
        logic [2*FIELD_W+1:0] wide;
        wide = {66'd0, base} + {66'd0, mul} * {66'd0, x};
        return (wide > {66'd0, FRAC_ONES}) ? FRAC_ONES : wide[FIELD_W-1:0];
    endfunction

    function automatic approx_t best_approx(input logic [FIELD_W-1:0]  top,
                                            input logic [FIELD_W-1:0]  bottom,
                                            input logic [RESULT_W-1:0] nlim,
                                            input logic [RESULT_W-1:0] dlim);
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        logic [FIELD_W-1:0] quo;
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] p_prev;
        logic [FIELD_W-1:0] q_prev;
        logic [FIELD_W-1:0] p_cur;
        logic [FIELD_W-1:0] q_cur;
        logic [FIELD_W-1:0] p_next;
        logic [FIELD_W-1:0] q_next;
        logic               done;
        approx_t            res;
        num    = top;
        den    = bottom;
        p_prev = '0;
        q_prev = 64'd1;
        p_cur  = 64'd1;
        q_cur  = '0;
        done   = 1'b0;
        while (!done)
        begin
            if (p_cur > {32'd0, nlim} || q_cur > {32'd0, dlim})
            begin
                // newest convergent over a limit, fall back one
                p_cur = p_prev;
                q_cur = q_prev;
                done  = 1'b1;
            end
            else if (den == '0)
            begin
                done = 1'b1;
            end
            else
            begin
                quo    = num / den;
                rem    = num % den;
                num    = den;
                den    = rem;
                p_next = sat_mac(p_prev, quo, p_cur);
                q_next = sat_mac(q_prev, quo, q_cur);
                p_prev = p_cur;
                q_prev = q_cur;
                p_cur  = p_next;
                q_cur  = q_next;
            end
        end
        res.top    = p_cur[RESULT_W-1:0];
        res.bottom = q_cur[RESULT_W-1:0];
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_frac(input int unsigned bits);
        logic [FIELD_W-1:0] v;
        v = {$urandom, $urandom};
        if (bits < FIELD_W)
        begin
            v = v & ((64'd1 << bits) - 64'd1);
        end
        return v;
    endfunction

    function automatic stim_row_t stim_row(input logic [RESULT_W-1:0] nlim,
                                           input logic [RESULT_W-1:0] dlim,
                                           input logic [FIELD_W-1:0]  top,
                                           input logic [FIELD_W-1:0]  bottom,
                                           input logic                typed,
                                           input logic [RESULT_W-1:0] known_top,
                                           input logic [RESULT_W-1:0] known_bottom);
        stim_row_t r;
        r.num_lim      = nlim;
        r.den_lim      = dlim;
        r.top          = top;
        r.bottom       = bottom;
        r.typed        = typed;
        r.known.top    = known_top;
        r.known.bottom = known_bottom;
        return r;
    endfunction

    task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_limits(input logic [RESULT_W-1:0] nlim,
                                input logic [RESULT_W-1:0] dlim);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b0, NUM_LIMIT_ADDR, '0, rd);
        if (rd !== nlim)
        begin
            $error("numerator_limit mismatch: expected %0d, got %0d", nlim, rd);
            mismatch_count++;
        end
        apb_xfer(1'b0, DEN_LIMIT_ADDR, '0, rd);
        if (rd !== dlim)
        begin
            $error("denominator_limit mismatch: expected %0d, got %0d", dlim, rd);
            mismatch_count++;
        end
    endtask

    task automatic set_limits(input logic [RESULT_W-1:0] nlim,
                              input logic [RESULT_W-1:0] dlim);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b1, NUM_LIMIT_ADDR, nlim, rd);
        apb_xfer(1'b1, DEN_LIMIT_ADDR, dlim, rd);
        num_limit = nlim;
        den_limit = dlim;
        check_limits(nlim, dlim);
    endtask

    task automatic wait_all_done();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_approx.size() != 0);
    endtask

    task automatic send_word(input logic [FIELD_W-1:0] top,
                             input logic [FIELD_W-1:0] bottom,
                             input approx_t            want);
        while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        fraction_top    <= top;
        fraction_bottom <= bottom;
        do
            @(posedge clk);
        while (!in_ready);
        pending_approx.push_back(want);
    endtask

    // result checker and output stall
    initial
    begin
        approx_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                approx_seen++;
                if (pending_approx.size() == 0)
                begin
                    $error("result word with no word pending: %0d/%0d",
                           approx_top, approx_bottom);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_approx.pop_front();
                    if (approx_top !== want.top)
                    begin
                        $error("approx_top mismatch: expected %0d, got %0d",
                               want.top, approx_top);
                        mismatch_count++;
                    end
                    if (approx_bottom !== want.bottom)
                    begin
                        $error("approx_bottom mismatch: expected %0d, got %0d",
                               want.bottom, approx_bottom);
                        mismatch_count++;
                    end
                end
            end
            if (approx_seen == HOLD_AT && !hold_done)
            begin
                // long hold-off so the block fills and stalls its input
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (approx_seen >= 300 && approx_seen < 380)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t           dir_rows[$];
        stim_row_t           r;
        logic [FIELD_W-1:0]  t;
        logic [FIELD_W-1:0]  b;
        logic [RESULT_W-1:0] nl;
        logic [RESULT_W-1:0] dl;
        int unsigned         w;
        int unsigned         sel;

        // zero fractions, all-ones fields, exact fractions and long expansions at reset limits
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, '0, '0, 1'b1, 32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, FRAC_ONES, '0, 1'b1, 32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, '0, 64'd7, 1'b1, 32'd0, 32'd1));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, 64'd355, 64'd113, 1'b1,
                                    32'd355, 32'd113));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, FRAC_ONES, 64'd1, 1'b1,
                                    32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, 64'd1, FRAC_ONES, 1'b1,
                                    32'd0, 32'd1));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, FRAC_ONES, FRAC_ONES, 1'b1,
                                    32'd1, 32'd1));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, FRAC_ONES, FRAC_ONES - 1,
                                    1'b0, '0, '0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, FIB_93, FIB_92, 1'b0, '0, '0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, 64'd3141592653589793238,
                                    64'd1000000000000000000, 1'b0, '0, '0));
        dir_rows.push_back(stim_row(LIMIT_RESET, LIMIT_RESET, {32{2'b01}}, {32{2'b10}},
                                    1'b0, '0, '0));
        // zero numerator limit
        dir_rows.push_back(stim_row('0, LIM_ONES, 64'd3, 64'd2, 1'b1, 32'd0, 32'd1));
        dir_rows.push_back(stim_row('0, LIM_ONES, '0, '0, 1'b1, 32'd0, 32'd1));
        // zero denominator limit
        dir_rows.push_back(stim_row(LIM_ONES, '0, 64'd3, 64'd2, 1'b1, 32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIM_ONES, '0, '0, 64'd5, 1'b1, 32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIM_ONES, '0, '0, '0, 1'b1, 32'd1, 32'd0));
        // widest limits
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, FRAC_ONES, 64'd1, 1'b1, 32'd1, 32'd0));
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, 64'd4294967295, 64'd1, 1'b1,
                                    LIM_ONES, 32'd1));
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, 64'd1, 64'd4294967295, 1'b1,
                                    32'd1, LIM_ONES));
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, FIB_93, FIB_92, 1'b0, '0, '0));
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, 64'h8000_0000_0000_0000, 64'd3,
                                    1'b0, '0, '0));
        dir_rows.push_back(stim_row(LIM_ONES, LIM_ONES, FRAC_ONES, FRAC_ONES - 1,
                                    1'b0, '0, '0));
        // tiny limits
        dir_rows.push_back(stim_row(32'd1, 32'd1, 64'd7, 64'd3, 1'b0, '0, '0));
        dir_rows.push_back(stim_row(32'd1, 32'd1, 64'd1, 64'd2, 1'b0, '0, '0));
        dir_rows.push_back(stim_row('0, '0, 64'd5, 64'd3, 1'b1, 32'd0, 32'd1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_limits(LIMIT_RESET, LIMIT_RESET);

        foreach (dir_rows[k])
        begin
            r = dir_rows[k];
            if (r.num_lim != num_limit || r.den_lim != den_limit)
            begin
                wait_all_done();
                set_limits(r.num_lim, r.den_lim);
            end
            send_word(r.top, r.bottom,
                      r.typed ? r.known : best_approx(r.top, r.bottom, num_limit, den_limit));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 5)
                0:
                begin
                    nl = LIM_ONES;
                    dl = LIM_ONES;
                end
                1:
                begin
                    nl = $urandom;
                    dl = $urandom;
                end
                2:
                begin
                    nl = $urandom_range(0, 300);
                    dl = $urandom_range(0, 300);
                end
                3:
                begin
                    nl = $urandom >> $urandom_range(0, 31);
                    dl = $urandom >> $urandom_range(0, 31);
                end
                default:
                begin
                    nl = $urandom_range(0, 1) ? LIM_ONES : '0;
                    dl = $urandom_range(0, 1) ? LIM_ONES : LIMIT_RESET;
                end
            endcase
            wait_all_done();
            set_limits(nl, dl);
            sender_calm = (ph == 2);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (ph == 5 && i == 30)
                begin
                    wait_all_done();
                end
                // mostly narrow fractions, a few at full width
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    w = $urandom_range(1, 20);
                else if (sel < 90)
                    w = $urandom_range(21, 48);
                else
                    w = FIELD_W;
                t = rand_frac(w);
                b = rand_frac(($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : w);
                if ($urandom_range(0, 49) == 0)
                    t = '0;
                if ($urandom_range(0, 49) == 0)
                    b = '0;
                send_word(t, b, best_approx(t, b, num_limit, den_limit));
            end
        end

        wait_all_done();
        repeat (END_IDLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
